// File: rtl/core/smon_pkg.sv
// Shared constants and types of the sliding window offset monitor.
package smon_pkg;

	localparam int CHANNELS_DEF           = 16;
	localparam int WINDOW_DEPTH_DEF       = 64;
	localparam int MAX_PACKET_SAMPLES_DEF = 4096;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd2;

	localparam int WPK_W = 7;
	localparam int RUN_W = 16;

	localparam logic [31:0]      THRESHOLD_RST = 32'd1048576;
	localparam logic [31:0]      PERIOD_RST    = 32'd60000;
	localparam logic [WPK_W-1:0] WINDOW_RST    = 7'd64;
	localparam logic [RUN_W-1:0] RUN_MAX       = 16'hFFFF;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CH_RD,
		S_ENT_RD,
		S_DIVIDE,
		S_FINISH
	} smon_state_t;

endpackage

// File: rtl/core/smon_ifs.sv
// Handshake interfaces for the sample, result and configuration channels.
interface smon_smp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  channel;
	logic [31:0] sample;
	logic [31:0] packet_time_ms;
	logic        packet_end;
	modport source (output valid, channel, sample, packet_time_ms, packet_end, input ready);
	modport sink (input valid, channel, sample, packet_time_ms, packet_end, output ready);
endinterface

interface smon_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  out_channel;
	logic        checked;
	logic [31:0] window_mean;
	logic        offscale;
	logic [15:0] offscale_run;
	modport source (output valid, out_channel, checked, window_mean, offscale, offscale_run,
		input ready);
	modport sink (input valid, out_channel, checked, window_mean, offscale, offscale_run,
		output ready);
endinterface

interface smon_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/smon_pkt_accum.sv
// Packet accumulator: sums the samples of the packet in progress.
module smon_pkt_accum #(
	parameter int MAX_PACKET_SAMPLES = smon_pkg::MAX_PACKET_SAMPLES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [31:0] sample,
	input  logic packet_end,
	output logic signed [32+$clog2(MAX_PACKET_SAMPLES)-1:0] pkt_sum,
	output logic [$clog2(MAX_PACKET_SAMPLES+1)-1:0] pkt_cnt
);
	import smon_pkg::*;

	localparam int ACC_W = 32 + $clog2(MAX_PACKET_SAMPLES);
	localparam int CNT_W = $clog2(MAX_PACKET_SAMPLES + 1);

	logic signed [ACC_W-1:0] acc_q, acc_nx;
	logic [CNT_W-1:0] cnt_q, cnt_nx;
	logic take;

	always_comb begin
		take   = cnt_q < CNT_W'(MAX_PACKET_SAMPLES);
		acc_nx = take ? acc_q + {{(ACC_W-32){sample[31]}}, sample} : acc_q;
		cnt_nx = take ? cnt_q + CNT_W'(1) : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (en) begin
			if (packet_end) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= acc_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && packet_end) begin
			pkt_sum <= acc_nx;
			pkt_cnt <= cnt_nx;
		end
	end

endmodule

// File: rtl/core/smon_div.sv
// Restoring divider that produces one quotient bit per cycle.
module smon_div #(
	parameter int N = 51,
	parameter int D = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic [N-1:0] quotient,
	output logic done
);
	import smon_pkg::*;

	localparam int C_W = $clog2(N + 1);

	logic busy_q, done_q;
	logic [C_W-1:0] cnt_q;
	logic [D-1:0] div_q;
	logic [D-1:0] rem_q;
	logic [N-1:0] quo_q;
	logic [D:0] trial, diff;
	logic fits;

	always_comb begin
		trial = {rem_q, quo_q[N-1]};
		fits  = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= C_W'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - C_W'(1);
				if (cnt_q == C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[D-1:0] : trial[D-1:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// File: rtl/core/sliding_window_offset_monitor.sv
// Top level of the per-channel sliding window DC offset monitor.
// Samples enter on smp, one word per accepted handshake, each tagged with a
// channel, a packet time and an end-of-packet flag. A sample that does not end
// a packet leaves the block ready for the next word. An end-of-packet word on
// a valid channel produces one result word on res; a word on an unused channel
// produces none. A valid one passes the channel read, entry read, divide (only
// when a check is due) and finish states; the bit-serial divider works over the
// window sum width (51 bits at the default sizes). No new sample is taken while
// it is processed. Per-channel state and the packet window entries sit in two
// single-port synchronous memories, read, updated and written back in turn.
// Registers are written on cfg: index 0 threshold, 1 check period in
// milliseconds, 2 window length in packets; they should change only when idle.
// Reset clears the packet sum, the per-channel seen flags (an unseen channel
// reads as zero state) and restores the register defaults; no clearing pass is
// needed. A stalled receiver holds the result in the output register; samples
// keep flowing until the next end-of-packet word needs that register.
module sliding_window_offset_monitor #(
	parameter int CHANNELS           = smon_pkg::CHANNELS_DEF,
	parameter int WINDOW_DEPTH       = smon_pkg::WINDOW_DEPTH_DEF,
	parameter int MAX_PACKET_SAMPLES = smon_pkg::MAX_PACKET_SAMPLES_DEF
) (
	input logic clk,
	input logic arst_n,
	smon_smp_if.sink smp,
	smon_res_if.source res,
	smon_cfg_if.sink cfg
);
	import smon_pkg::*;

	localparam int CHA_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SL_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int WIN_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int OW     = WIN_W + 1;
	localparam int CNT_W  = $clog2(MAX_PACKET_SAMPLES + 1);
	localparam int ACC_W  = 32 + $clog2(MAX_PACKET_SAMPLES);
	localparam int WSUM_W = ACC_W + WIN_W;
	localparam int WSMP_W = CNT_W + WIN_W;
	localparam int WPC_W  = (WIN_W > WPK_W) ? WIN_W : WPK_W;
	localparam int EA_W   = CHA_W + SL_W;
	localparam int ENT_DEPTH = CHANNELS << SL_W;

	typedef struct packed {
		logic [SL_W-1:0]   head;
		logic [WIN_W-1:0]  fill;
		logic [WSUM_W-1:0] sum;
		logic [WSMP_W-1:0] samples;
		logic [31:0]       last;
		logic [RUN_W-1:0]  run;
	} chan_rec_t;

	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	smon_state_t state_q, state_nx;

	logic [31:0] thr_q, period_q;
	logic [WPK_W-1:0] wpk_q;

	logic signed [ACC_W-1:0] pkt_sum;
	logic [CNT_W-1:0] pkt_cnt;

	logic smp_acc, ch_ok, go;
	logic [CHA_W+3:0] ch_ext;
	logic [CHA_W-1:0] ch_q;
	logic [3:0] chraw_q;
	logic [31:0] t_q;
	logic [CHANNELS-1:0] seen_q;

	chan_rec_t chan_mem [CHANNELS];
	chan_rec_t chan_rd_q, cur_rec, rec_q, upd_q, upd_nx, fin_rec;
	entry_t ent_mem [ENT_DEPTH];
	entry_t ent_rd_q;

	logic [WPC_W-1:0] eff_w;
	logic drop, drop_q;
	logic [OW-1:0] hx, fx, old_o;
	logic [SL_W-1:0] old_idx;
	logic [SL_W:0] head_inc;

	logic [WSUM_W-1:0] ent_sum_x, pkt_sum_x;
	logic [WSMP_W-1:0] samp1;
	logic chk_now, chk_q, sign_q, zero_q;
	logic [WSUM_W-1:0] dvd_mag;

	logic div_start, div_done;
	logic [WSUM_W-1:0] div_quo;
	logic [32:0] q_mag, mean33;
	logic off;

	logic ent_re, ent_we, upd_en, out_load, chan_we;

	logic res_valid_q;
	logic [3:0] res_ch_q;
	logic res_chk_q, res_off_q;
	logic [31:0] res_mean_q;
	logic [RUN_W-1:0] res_run_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THRESHOLD_RST;
			period_q <= PERIOD_RST;
			wpk_q    <= WINDOW_RST;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_THRESHOLD) thr_q <= cfg.data;
			if (cfg.index == CFG_PERIOD) period_q <= cfg.data;
			if (cfg.index == CFG_WINDOW) wpk_q <= cfg.data[WPK_W-1:0];
		end
	end

	assign smp_acc = smp.valid && smp.ready;
	assign ch_ext  = {{CHA_W{1'b0}}, smp.channel};
	assign ch_ok   = ch_ext < (CHA_W+4)'(CHANNELS);
	assign go      = smp_acc && smp.packet_end && ch_ok;

	smon_pkt_accum #(
		.MAX_PACKET_SAMPLES(MAX_PACKET_SAMPLES)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.en(smp_acc),
		.sample(smp.sample),
		.packet_end(smp.packet_end),
		.pkt_sum(pkt_sum),
		.pkt_cnt(pkt_cnt)
	);

	// Channel state memory; an unseen channel reads as zero, its last time set to t_q.
	always_ff @(posedge clk) begin
		if (chan_we) chan_mem[ch_q] <= fin_rec;
		if (go) chan_rd_q <= chan_mem[ch_ext[CHA_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (chan_we) begin
			seen_q[ch_q] <= 1'b1;
		end
	end

	always_comb begin
		if (seen_q[ch_q]) begin
			cur_rec = chan_rd_q;
		end else begin
			cur_rec      = '0;
			cur_rec.last = t_q;
		end
		if (wpk_q == '0) eff_w = WPC_W'(1);
		else if (WPC_W'(wpk_q) > WPC_W'(WINDOW_DEPTH)) eff_w = WPC_W'(WINDOW_DEPTH);
		else eff_w = WPC_W'(wpk_q);
		drop    = WPC_W'(cur_rec.fill) >= eff_w;
		hx      = OW'(cur_rec.head);
		fx      = OW'(cur_rec.fill);
		old_o   = (hx >= fx) ? hx - fx : hx + OW'(WINDOW_DEPTH) - fx;
		old_idx = old_o[SL_W-1:0];
	end

	// Window entry memory; the oldest entry is read in the cycle before the new one is written.
	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[{ch_q, rec_q.head}] <= {pkt_sum, pkt_cnt};
		if (ent_re) ent_rd_q <= ent_mem[{ch_q, old_idx}];
	end

	always_comb begin
		ent_sum_x = {{WIN_W{ent_rd_q.sum[ACC_W-1]}}, ent_rd_q.sum};
		pkt_sum_x = {{WIN_W{pkt_sum[ACC_W-1]}}, pkt_sum};
		head_inc  = (SL_W+1)'(rec_q.head) + (SL_W+1)'(1);
		upd_nx      = rec_q;
		upd_nx.head = (head_inc >= (SL_W+1)'(WINDOW_DEPTH)) ? '0 : head_inc[SL_W-1:0];
		upd_nx.fill = rec_q.fill - WIN_W'(drop_q) + WIN_W'(1);
		upd_nx.sum  = rec_q.sum - (drop_q ? ent_sum_x : '0) + pkt_sum_x;
		samp1       = rec_q.samples - (drop_q ? WSMP_W'(ent_rd_q.cnt) : '0) + WSMP_W'(pkt_cnt);
		upd_nx.samples = samp1;
		chk_now = (t_q >= rec_q.last) && ((t_q - rec_q.last) >= period_q);
		dvd_mag = upd_nx.sum[WSUM_W-1] ? '0 - upd_nx.sum : upd_nx.sum;
	end

	smon_div #(
		.N(WSUM_W),
		.D(WSMP_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dvd_mag),
		.divisor(samp1),
		.quotient(div_quo),
		.done(div_done)
	);

	always_comb begin
		q_mag   = zero_q ? '0 : div_quo[32:0];
		mean33  = sign_q ? '0 - q_mag : q_mag;
		off     = chk_q && (q_mag >= {1'b0, thr_q});
		fin_rec = upd_q;
		if (chk_q) begin
			fin_rec.last = t_q;
			if (off) begin
				fin_rec.sum     = '0;
				fin_rec.samples = '0;
				fin_rec.fill    = '0;
				fin_rec.run     = (upd_q.run == RUN_MAX) ? upd_q.run : upd_q.run + RUN_W'(1);
			end else begin
				fin_rec.run = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:   if (go) state_nx = S_CH_RD;
			S_CH_RD:  state_nx = S_ENT_RD;
			S_ENT_RD: state_nx = chk_now ? S_DIVIDE : S_FINISH;
			S_DIVIDE: if (div_done) state_nx = S_FINISH;
			S_FINISH: if (out_load) state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		smp.ready = 1'b0;
		ent_re    = 1'b0;
		ent_we    = 1'b0;
		upd_en    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE:   smp.ready = 1'b1;
			S_CH_RD:  ent_re = 1'b1;
			S_ENT_RD: begin
				ent_we    = 1'b1;
				upd_en    = 1'b1;
				div_start = chk_now;
			end
			S_DIVIDE: ;
			S_FINISH: out_load = !res_valid_q || res.ready;
			default:  ;
		endcase
	end

	assign chan_we = out_load;

	always_ff @(posedge clk) begin
		if (go) begin
			ch_q    <= ch_ext[CHA_W-1:0];
			chraw_q <= smp.channel;
			t_q     <= smp.packet_time_ms;
		end
		if (ent_re) begin
			rec_q  <= cur_rec;
			drop_q <= drop;
		end
		if (upd_en) begin
			upd_q  <= upd_nx;
			chk_q  <= chk_now;
			sign_q <= upd_nx.sum[WSUM_W-1];
			zero_q <= samp1 == '0;
		end
		if (out_load) begin
			res_ch_q   <= chraw_q;
			res_chk_q  <= chk_q;
			res_mean_q <= chk_q ? mean33[31:0] : '0;
			res_off_q  <= off;
			res_run_q  <= chk_q ? fin_rec.run : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (out_load) res_valid_q <= 1'b1;
		else if (res.ready) res_valid_q <= 1'b0;
	end

	assign res.valid        = res_valid_q;
	assign res.out_channel  = res_ch_q;
	assign res.checked      = res_chk_q;
	assign res.window_mean  = res_mean_q;
	assign res.offscale     = res_off_q;
	assign res.offscale_run = res_run_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chan_we |-> fin_rec.fill <= WIN_W'(WINDOW_DEPTH))
		else $error("Window fill written back beyond the window depth.");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chan_we |-> (SL_W+1)'(fin_rec.head) < (SL_W+1)'(WINDOW_DEPTH))
		else $error("Window head written back outside the window.");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> samp1 != '0)
		else $error("Mean division started with an empty window.");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVIDE)
		else $error("Divider finished outside the divide state.");

endmodule

// File: tb/sliding_window_offset_monitor_tb.sv
// Self-checking testbench of the sliding window offset monitor, with its own predictor.
`timescale 1ns / 100ps

module sliding_window_offset_monitor_tb;
	import smon_pkg::*;

	localparam int NCH      = CHANNELS_DEF;
	localparam int DEPTH    = WINDOW_DEPTH_DEF;
	localparam int MAXSMP   = MAX_PACKET_SAMPLES_DEF;
	localparam int SETTLE   = 120;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [3:0]  ch;
		logic        checked;
		logic [31:0] mean;
		logic        off;
		logic [15:0] run;
	} offset_result_t;

	logic clk;
	logic arst_n;

	smon_smp_if smp();
	smon_res_if res();
	smon_cfg_if cfg();

	sliding_window_offset_monitor uut (
		.clk(clk), .arst_n(arst_n), .smp(smp), .res(res), .cfg(cfg)
	);

	// Predictor state.
	logic [31:0]        thr_q;
	logic [31:0]        period_q;
	logic [6:0]         wpk_q;
	logic signed [63:0] pkt_sum;
	int unsigned        pkt_cnt;
	logic signed [63:0] slot_sum [NCH][DEPTH];
	int unsigned        slot_cnt [NCH][DEPTH];
	int unsigned        win_head [NCH];
	int unsigned        win_fill [NCH];
	logic signed [63:0] win_sum [NCH];
	int unsigned        win_cnt [NCH];
	logic [31:0]        last_ms [NCH];
	int unsigned        run_len [NCH];
	bit                 seen [NCH];

	offset_result_t pending_results[$];
	int errors;
	int packets_done;
	int checks_seen;
	int offscale_seen;
	bit quiet;
	bit hold_req;
	int hold_left;
	logic [31:0] chan_ms [NCH];

	function automatic void predict_word(logic [3:0] ch, logic [31:0] raw, logic [31:0] t,
			logic pend);
		offset_result_t r;
		int unsigned w;
		int unsigned old;
		logic signed [63:0] mean;
		logic [63:0] mag;
		if (pkt_cnt < MAXSMP) begin
			pkt_sum += 64'(signed'(raw));
			pkt_cnt++;
		end
		if (!pend)
			return;
		w = (wpk_q == 0) ? 1 : ((wpk_q > DEPTH) ? DEPTH : wpk_q);
		if (!seen[ch]) begin
			seen[ch] = 1;
			last_ms[ch] = t;
		end
		if (win_fill[ch] >= w) begin
			old = (win_head[ch] + DEPTH - win_fill[ch]) % DEPTH;
			win_sum[ch] -= slot_sum[ch][old];
			win_cnt[ch] -= slot_cnt[ch][old];
			win_fill[ch]--;
		end
		slot_sum[ch][win_head[ch]] = pkt_sum;
		slot_cnt[ch][win_head[ch]] = pkt_cnt;
		win_head[ch] = (win_head[ch] + 1 >= DEPTH) ? 0 : win_head[ch] + 1;
		win_fill[ch]++;
		win_sum[ch] += pkt_sum;
		win_cnt[ch] += pkt_cnt;
		pkt_sum = 0;
		pkt_cnt = 0;
		r.ch = ch;
		r.checked = 0;
		r.mean = 0;
		r.off = 0;
		r.run = 0;
		if (t >= last_ms[ch] && (t - last_ms[ch]) >= period_q) begin
			r.checked = 1;
			mean = 0;
			if (win_cnt[ch] != 0)
				mean = win_sum[ch] / $signed({32'd0, win_cnt[ch]});
			mag = (mean < 0) ? -mean : mean;
			if (mag >= {32'd0, thr_q}) begin
				r.off = 1;
				win_sum[ch] = 0;
				win_cnt[ch] = 0;
				win_fill[ch] = 0;
				if (run_len[ch] < 65535)
					run_len[ch]++;
			end else begin
				run_len[ch] = 0;
			end
			last_ms[ch] = t;
			r.mean = mean[31:0];
			r.run = run_len[ch][15:0];
		end
		pending_results.push_back(r);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		offset_result_t e;
		if (arst_n && res.valid && res.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", res.out_channel, 0);
			end else begin
				e = pending_results.pop_front();
				if (res.out_channel !== e.ch) report_mismatch("out_channel", res.out_channel, e.ch);
				if (res.checked !== e.checked) report_mismatch("checked", res.checked, e.checked);
				if (res.window_mean !== e.mean) report_mismatch("window_mean", res.window_mean, e.mean);
				if (res.offscale !== e.off) report_mismatch("offscale", res.offscale, e.off);
				if (res.offscale_run !== e.run) report_mismatch("offscale_run", res.offscale_run, e.run);
				packets_done++;
				if (e.checked) checks_seen++;
				if (e.off) offscale_seen++;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req <= 0;
			hold_left <= 400;
			res.ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res.ready <= 0;
		end else begin
			res.ready <= quiet || ($urandom_range(0, 99) >= 32);
		end
	end

	int stall_cycles;
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		@(negedge clk);
		smp.valid <= 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		wait_drained();
		@(negedge clk);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			CFG_THRESHOLD: thr_q = val;
			CFG_PERIOD: period_q = val;
			default: wpk_q = val[6:0];
		endcase
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic send_word(logic [3:0] ch, logic [31:0] s, logic [31:0] t, logic pend);
		int gap;
		if (!quiet && $urandom_range(0, 99) < 32) begin
			@(negedge clk);
			smp.valid <= 0;
			gap = $urandom_range(0, 3);
			repeat (gap) @(negedge clk);
		end
		@(negedge clk);
		smp.valid <= 1;
		smp.channel <= ch;
		smp.sample <= s;
		smp.packet_time_ms <= t;
		smp.packet_end <= pend;
		do @(posedge clk); while (!smp.ready);
		predict_word(ch, s, t, pend);
	endtask

	task automatic send_packet(logic [3:0] ch, int n, logic [31:0] base, int unsigned spread,
			logic [31:0] t);
		logic [31:0] s;
		for (int i = 0; i < n; i++) begin
			s = base + $urandom_range(0, spread) - spread / 2;
			send_word(ch, s, t, i == n - 1);
		end
	endtask

	task automatic test_extremes();
		send_packet(0, 1, 32'h8000_0000, 0, 0);
		send_packet(0, 2, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF);
		send_packet(15, 3, 32'h8000_0000, 0, 32'd60000);
		send_packet(15, 1, 32'hFFFF_FFFF, 0, 32'd120000);
		send_packet(15, 2, 32'h0010_0000, 0, 32'd180000);
		send_packet(3, 1, 0, 0, 32'hFFFF_FFFF);
	endtask

	task automatic test_time_backwards();
		cfg_write(CFG_PERIOD, 0);
		send_packet(5, 2, 32'd100, 4, 32'd1000);
		send_packet(5, 2, 32'd100, 4, 32'd500);
		send_packet(5, 1, 32'd100, 4, 32'd1000);
	endtask

	task automatic test_zero_threshold();
		cfg_write(CFG_THRESHOLD, 0);
		send_packet(6, 2, 32'd3, 2, 32'd10);
		send_packet(6, 2, 32'd3, 2, 32'd11);
		send_packet(6, 1, 32'hFFFF_FFF0, 0, 32'd12);
	endtask

	task automatic test_window_edges();
		cfg_write(CFG_THRESHOLD, 32'h8000_0000);
		cfg_write(CFG_WINDOW, 0);
		send_packet(7, 2, 32'd50, 10, 32'd1);
		send_packet(7, 2, 32'hFFFF_FF00, 10, 32'd2);
		cfg_write(CFG_WINDOW, 127);
		for (int i = 0; i < 4; i++)
			send_packet(7, 1, 32'd1000 * i, 10, 32'd3 + i);
		cfg_write(CFG_WINDOW, 2);
		for (int i = 0; i < 4; i++)
			send_packet(7, 1, 32'd7, 3, 32'd10 + i);
	endtask

	task automatic random_phase(int npackets, logic [31:0] base, int unsigned spread);
		logic [3:0]  ch;
		logic [31:0] t;
		int k;
		for (int p = 0; p < npackets; p++) begin
			ch = $urandom_range(0, NCH - 1);
			k = $urandom_range(0, 99);
			chan_ms[ch] += $urandom_range(0, 2 * period_q > 40 ? 40 : 2 * period_q + 2);
			t = chan_ms[ch];
			if (k < 5)
				t = $urandom;
			else if (k < 10)
				t = chan_ms[ch] - $urandom_range(1, 50);
			if (k >= 95)
				send_packet(ch, $urandom_range(1, 3), $urandom, 32'hFFFF_FFFF, t);
			else
				send_packet(ch, $urandom_range(1, 6), base + $urandom_range(0, 64), spread, t);
		end
	endtask

	task automatic test_random();
		for (int i = 0; i < NCH; i++)
			chan_ms[i] = 0;
		cfg_write(CFG_THRESHOLD, 32'd1000);
		cfg_write(CFG_PERIOD, 3);
		cfg_write(CFG_WINDOW, 4);
		random_phase(70, 32'd900, 400);
		quiet = 1;
		cfg_write(CFG_PERIOD, 0);
		cfg_write(CFG_WINDOW, 1);
		random_phase(60, 32'hFFFF_FC00, 300);
		quiet = 0;
		cfg_write(CFG_THRESHOLD, 1);
		cfg_write(CFG_WINDOW, 64);
		cfg_write(CFG_PERIOD, 10);
		random_phase(60, 32'd0, 4);
		cfg_write(CFG_THRESHOLD, 32'h4000_0000);
		cfg_write(CFG_WINDOW, 3);
		random_phase(60, 32'h7FFF_FF00, 512);
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		random_phase(80, 32'd200, 100);
	endtask

	task automatic test_long_period();
		cfg_write(CFG_PERIOD, 32'hFFFF_FFFF);
		send_packet(9, 1, 32'd5, 0, 0);
		send_packet(9, 1, 32'd5, 0, 32'hFFFF_FFFE);
		send_packet(10, 1, 32'd5, 0, 0);
		send_packet(10, 1, 32'd5, 0, 32'hFFFF_FFFF);
	endtask

	initial begin
		arst_n = 0;
		smp.valid = 0;
		smp.channel = 0;
		smp.sample = 0;
		smp.packet_time_ms = 0;
		smp.packet_end = 0;
		cfg.valid = 0;
		cfg.index = CFG_THRESHOLD;
		cfg.data = 0;
		res.ready = 0;
		quiet = 0;
		hold_req = 0;
		hold_left = 0;
		errors = 0;
		packets_done = 0;
		checks_seen = 0;
		offscale_seen = 0;
		stall_cycles = 0;
		thr_q = THRESHOLD_RST;
		period_q = PERIOD_RST;
		wpk_q = WINDOW_RST;
		pkt_sum = 0;
		pkt_cnt = 0;
		for (int c = 0; c < NCH; c++) begin
			win_head[c] = 0;
			win_fill[c] = 0;
			win_sum[c] = 0;
			win_cnt[c] = 0;
			last_ms[c] = 0;
			run_len[c] = 0;
			seen[c] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_extremes();
		test_time_backwards();
		test_zero_threshold();
		test_window_edges();
		test_long_period();
		test_random();
		test_backpressure();

		@(negedge clk);
		smp.valid <= 0;
		wait_drained();
		$display("Run covered %0d completed packets, %0d mean checks, %0d offscale.",
			packets_done, checks_seen, offscale_seen);
		$display("Register extremes, window sizes, time reversal and a long stall were driven.");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: sliding_window_offset_monitor.f
rtl/core/smon_pkg.sv
rtl/core/smon_ifs.sv
rtl/core/smon_pkt_accum.sv
rtl/core/smon_div.sv
rtl/core/sliding_window_offset_monitor.sv
tb/sliding_window_offset_monitor_tb.sv
